### src/fsrt_pkg.sv
package fsrt_pkg;

  localparam int NUM_LOGICAL_DEF = 16;
  localparam int NUM_SLOTS_DEF   = 256;

  localparam int LG_W   = 8;
  localparam int HDR_W  = 16;
  localparam int SLOT_W = 8;
  localparam int NFS_W  = 9;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  localparam logic [HDR_W-1:0] HDR_FREE = 16'hFFFF;
  localparam logic [HDR_W-1:0] HDR_USED = 16'h0000;

  typedef enum logic [1:0] {
    REQ_SCAN   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CMD_PROGRAM = 2'd0,
    CMD_MARK    = 2'd1,
    CMD_STATUS  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd_kind;
    logic [SLOT_W-1:0] slot_index;
    logic [HDR_W-1:0]  header_value;
    logic              success;
    logic              is_mapped;
    logic              store_full;
    logic              scan_finished;
    logic              bad_header;
    logic              last_of_run;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       emit;
    logic [1:0] emit_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] n_res;
  } dp_sts_t;

endpackage

### src/flash_sector_remap_table.sv
// Sector remap table for append-only flash. Logical sectors 1..NUM_LOGICAL map
// to physical slots taken in order from a next-free pointer; scan transfers
// rebuild the map one slot header at a time, and write, delete and read
// transfers each produce a short run of results (program command, mark command,
// status), the final one flagged by out_tlast. The request kind travels on
// in_tuser and the result kind on out_tuser. A request passes through capture,
// slot memory lookup with its registered read, and update; its results are then
// loaded one at a time into the single output register, each as soon as that
// register is free. The next request is taken as soon as the last result of the
// previous one sits in the output register. Slot numbers are held in a small
// memory that needs no clearing pass; per-sector valid bits clear at reset.
module flash_sector_remap_table import fsrt_pkg::*; #(
  parameter int NUM_LOGICAL = NUM_LOGICAL_DEF,
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // logical_number[7:0], header_word[23:8], slot_all_erased[24],
  // checksum_match[25], same_data[26], program_ok[27], mark_ok[28], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // slot_index[7:0], header_value[23:8], success[24], is_mapped[25],
  // store_full[26], scan_finished[27], bad_header[28], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // cmd_kind[1:0]
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  res_t     res;

  fsrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsrt_dp #(
    .NUM_LOGICAL(NUM_LOGICAL),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (res)
  );

  assign out_tdata = {3'b000, res.bad_header, res.scan_finished, res.store_full,
                      res.is_mapped, res.success, res.header_value, res.slot_index};
  assign out_tuser = res.cmd_kind;
  assign out_tlast = res.last_of_run;

endmodule

### src/fsrt_ram.sv
module fsrt_ram import fsrt_pkg::*; #(
  parameter int WIDTH = SLOT_W,
  parameter int DEPTH = NUM_LOGICAL_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/fsrt_ctrl.sv
module fsrt_ctrl import fsrt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       slot_free;

  assign slot_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    cmd.emit_idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        idx_nxt   = 2'd0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit       = 1'b1;
          out_tvalid_nxt = 1'b1;
          idx_nxt        = idx_r + 2'd1;
          // The result register is loaded with the last item, so the input side reopens.
          if (idx_r == sts.n_res - 2'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= 2'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

### src/fsrt_dp.sv
module fsrt_dp import fsrt_pkg::*; #(
  parameter int NUM_LOGICAL = NUM_LOGICAL_DEF,
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]            in_tuser,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  output res_t                  out_res
);

  localparam int LIDX_W = (NUM_LOGICAL > 1) ? $clog2(NUM_LOGICAL) : 1;
  localparam logic [LG_W-1:0]  NL_LG  = LG_W'(NUM_LOGICAL);
  localparam logic [HDR_W-1:0] NL_HDR = HDR_W'(NUM_LOGICAL);
  localparam logic [NFS_W-1:0] NS     = NFS_W'(NUM_SLOTS);

  // Latched request.
  req_t              req_r;
  logic [LG_W-1:0]   lg_r;
  logic [HDR_W-1:0]  hdr_r;
  logic              erased_r, csok_r, same_r, pok_r, mkok_r;

  // Table state.
  logic [NUM_LOGICAL-1:0] map_valid_r;
  logic [NFS_W-1:0]       nfs_r, nfs_nxt;
  logic                   stop_r, stop_nxt;

  res_t       res_r [3];
  res_t       res_nxt [3];
  logic [1:0] n_res_r, n_res_nxt;
  res_t       out_r;

  logic              vwe, vval;
  logic [LIDX_W-1:0] vidx;
  logic              ram_we;
  logic [LIDX_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] mslot;

  logic [LIDX_W-1:0] v, hv;
  logic              lg_ok, vld, full_now, full_aft, fin_aft;
  logic [SLOT_W-1:0] cur_slot, new_slot;

  function automatic res_t mk_cmd(cmd_t kind, logic [SLOT_W-1:0] slot,
                                  logic [HDR_W-1:0] hdr);
    res_t r;
    r              = '0;
    r.cmd_kind     = kind;
    r.slot_index   = slot;
    r.header_value = hdr;
    return r;
  endfunction

  function automatic res_t mk_sts(logic [SLOT_W-1:0] slot, logic ok, logic mapped,
                                  logic bad, logic full, logic fin);
    res_t r;
    r               = '0;
    r.cmd_kind      = CMD_STATUS;
    r.slot_index    = slot;
    r.success       = ok;
    r.is_mapped     = mapped;
    r.store_full    = full;
    r.scan_finished = fin;
    r.bad_header    = bad;
    r.last_of_run   = 1'b1;
    return r;
  endfunction

  // The slot memory is only written in the update cycle of a request.
  fsrt_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(NUM_LOGICAL)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we & cmd.exec),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(v),
    .rdata(mslot)
  );

  assign v        = LIDX_W'(lg_r - LG_W'(1));
  assign hv       = LIDX_W'(hdr_r - HDR_W'(1));
  assign lg_ok    = (lg_r != '0) && (lg_r <= NL_LG);
  assign vld      = lg_ok && map_valid_r[v];
  assign cur_slot = vld ? mslot : '0;
  assign new_slot = nfs_r[SLOT_W-1:0];
  assign full_now = (nfs_r >= NS);
  assign full_aft = (nfs_nxt >= NS);
  assign fin_aft  = stop_nxt || full_aft;

  // State effects of the request; the status fields need the updated state,
  // so the result list is built in a second pass below.
  always_comb begin
    nfs_nxt   = nfs_r;
    stop_nxt  = stop_r;
    vwe       = 1'b0;
    vidx      = v;
    vval      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = v;
    ram_wdata = new_slot;
    unique case (req_r)
      REQ_SCAN: begin
        if (!stop_r && !full_now) begin
          if (hdr_r == HDR_FREE && erased_r) begin
            stop_nxt = 1'b1;
          end else begin
            if (hdr_r != HDR_FREE && hdr_r != HDR_USED && hdr_r <= NL_HDR && csok_r) begin
              vwe       = 1'b1;
              vidx      = hv;
              vval      = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = hv;
            end
            nfs_nxt = nfs_r + NFS_W'(1);
            if (nfs_r + NFS_W'(1) >= NS) begin
              stop_nxt = 1'b1;
            end
          end
        end
      end
      REQ_DELETE: begin
        if (vld) begin
          vwe  = 1'b1;
          vval = 1'b0;
        end
      end
      REQ_WRITE: begin
        if (lg_ok && !(vld && same_r) && !full_now) begin
          nfs_nxt = nfs_r + NFS_W'(1);
          if (pok_r) begin
            vwe    = 1'b1;
            vval   = vld ? mkok_r : 1'b1;
            ram_we = vld ? mkok_r : 1'b1;
          end
        end
      end
      REQ_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt[0] = mk_sts('0, 1'b0, 1'b0, 1'b0, full_aft, fin_aft);
    res_nxt[1] = res_nxt[0];
    res_nxt[2] = res_nxt[0];
    n_res_nxt  = 2'd1;
    priority if (req_r == REQ_SCAN) begin
      if (stop_r || full_now) begin
        res_nxt[0] = mk_sts('0, 1'b1, 1'b0, 1'b0, full_aft, fin_aft);
      end else if (hdr_r == HDR_FREE && erased_r) begin
        res_nxt[0] = mk_sts(new_slot, 1'b1, 1'b0, 1'b0, full_aft, fin_aft);
      end else if (hdr_r == HDR_FREE || hdr_r == HDR_USED) begin
        res_nxt[0] = mk_sts(new_slot, 1'b1, 1'b0, 1'b0, full_aft, fin_aft);
      end else if (hdr_r <= NL_HDR) begin
        res_nxt[0] = mk_sts(new_slot, csok_r, csok_r || map_valid_r[hv], 1'b0,
                            full_aft, fin_aft);
      end else begin
        res_nxt[0] = mk_sts(new_slot, 1'b0, 1'b0, 1'b1, full_aft, fin_aft);
      end
    end else if (!lg_ok) begin
      res_nxt[0] = mk_sts('0, 1'b0, 1'b0, 1'b0, full_aft, fin_aft);
    end else if (req_r == REQ_READ) begin
      res_nxt[0] = mk_sts(cur_slot, 1'b1, vld, 1'b0, full_aft, fin_aft);
    end else if (req_r == REQ_DELETE) begin
      if (!vld) begin
        res_nxt[0] = mk_sts('0, 1'b1, 1'b0, 1'b0, full_aft, fin_aft);
      end else begin
        res_nxt[0] = mk_cmd(CMD_MARK, mslot, HDR_USED);
        res_nxt[1] = mk_sts('0, mkok_r, 1'b0, 1'b0, full_aft, fin_aft);
        n_res_nxt  = 2'd2;
      end
    end else begin
      if (vld && same_r) begin
        res_nxt[0] = mk_sts(mslot, 1'b1, 1'b1, 1'b0, full_aft, fin_aft);
      end else if (full_now) begin
        res_nxt[0] = mk_sts(cur_slot, 1'b0, vld, 1'b0, full_aft, fin_aft);
      end else begin
        res_nxt[0] = mk_cmd(CMD_PROGRAM, new_slot, HDR_W'(lg_r));
        if (!pok_r) begin
          res_nxt[1] = mk_sts(cur_slot, 1'b0, vld, 1'b0, full_aft, fin_aft);
          n_res_nxt  = 2'd2;
        end else if (vld) begin
          res_nxt[1] = mk_cmd(CMD_MARK, mslot, HDR_USED);
          res_nxt[2] = mkok_r ? mk_sts(new_slot, 1'b1, 1'b1, 1'b0, full_aft, fin_aft)
                              : mk_sts('0, 1'b0, 1'b0, 1'b0, full_aft, fin_aft);
          n_res_nxt  = 2'd3;
        end else begin
          res_nxt[1] = mk_sts(new_slot, 1'b1, 1'b1, 1'b0, full_aft, fin_aft);
          n_res_nxt  = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
      nfs_r       <= '0;
      stop_r      <= 1'b0;
      n_res_r     <= 2'd1;
    end else if (cmd.exec) begin
      if (vwe) begin
        map_valid_r[vidx] <= vval;
      end
      nfs_r   <= nfs_nxt;
      stop_r  <= stop_nxt;
      n_res_r <= n_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= req_t'(in_tuser);
      lg_r     <= in_tdata[7:0];
      hdr_r    <= in_tdata[23:8];
      erased_r <= in_tdata[24];
      csok_r   <= in_tdata[25];
      same_r   <= in_tdata[26];
      pok_r    <= in_tdata[27];
      mkok_r   <= in_tdata[28];
    end
    if (cmd.exec) begin
      res_r[0] <= res_nxt[0];
      res_r[1] <= res_nxt[1];
      res_r[2] <= res_nxt[2];
    end
    if (cmd.emit) begin
      unique case (cmd.emit_idx)
        2'd0:    out_r <= res_r[0];
        2'd1:    out_r <= res_r[1];
        default: out_r <= res_r[2];
      endcase
    end
  end

  assign sts.n_res = n_res_r;
  assign out_res   = out_r;

endmodule

### test/remap_checker.sv
module remap_checker import fsrt_pkg::*; #(
  parameter int NUM_LOGICAL = NUM_LOGICAL_DEF,
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]             out_tuser,
  input  logic                   out_tlast,
  output int                     mismatch_count,
  output int                     awaited_count
);

  // Shadow copy of the remap table. Slot numbers are only looked at while the
  // sector is live, so they are left unreset like the block's memory.
  logic              sector_live [NUM_LOGICAL];
  logic [SLOT_W-1:0] sector_slot [NUM_LOGICAL];
  int                next_slot;
  logic              scan_halted;
  res_t              awaited_cmds [$];

  function automatic logic store_is_full();
    return next_slot >= NUM_SLOTS;
  endfunction

  function automatic void expect_cmd(cmd_t kind, logic [SLOT_W-1:0] slot,
                                     logic [HDR_W-1:0] hdr);
    res_t r;
    r              = '0;
    r.cmd_kind     = kind;
    r.slot_index   = slot;
    r.header_value = hdr;
    awaited_cmds.push_back(r);
  endfunction

  // Status is built from the state left behind by the request.
  function automatic void expect_status(logic [SLOT_W-1:0] slot, logic ok,
                                        logic mapped, logic bad);
    res_t r;
    r               = '0;
    r.cmd_kind      = CMD_STATUS;
    r.slot_index    = slot;
    r.success       = ok;
    r.is_mapped     = mapped;
    r.store_full    = store_is_full();
    r.scan_finished = scan_halted | store_is_full();
    r.bad_header    = bad;
    r.last_of_run   = 1'b1;
    awaited_cmds.push_back(r);
  endfunction

  function automatic void predict_request(req_t req, logic [IN_TDATA_W-1:0] d);
    logic [LG_W-1:0]   lg;
    logic [HDR_W-1:0]  hdr;
    logic              erased, csum, same, prog, mark;
    logic              live, ok, bad, mapped;
    logic [SLOT_W-1:0] old, fresh;
    int                idx;
    lg     = d[7:0];
    hdr    = d[23:8];
    erased = d[24];
    csum   = d[25];
    same   = d[26];
    prog   = d[27];
    mark   = d[28];

    if (req == REQ_SCAN) begin
      if (scan_halted || store_is_full()) begin
        expect_status('0, 1'b1, 1'b0, 1'b0);
        return;
      end
      fresh = SLOT_W'(next_slot);
      if (hdr == HDR_FREE && erased) begin
        scan_halted = 1'b1;
        expect_status(fresh, 1'b1, 1'b0, 1'b0);
        return;
      end
      ok     = 1'b1;
      bad    = 1'b0;
      mapped = 1'b0;
      if (hdr != HDR_FREE && hdr != HDR_USED) begin
        if (int'(hdr) <= NUM_LOGICAL) begin
          idx = int'(hdr) - 1;
          if (csum) begin
            sector_live[idx] = 1'b1;
            sector_slot[idx] = fresh;
          end else begin
            ok = 1'b0;
          end
          mapped = sector_live[idx];
        end else begin
          bad = 1'b1;
          ok  = 1'b0;
        end
      end
      next_slot++;
      if (store_is_full()) scan_halted = 1'b1;
      expect_status(fresh, ok, mapped, bad);
      return;
    end

    if (lg == '0 || int'(lg) > NUM_LOGICAL) begin
      expect_status('0, 1'b0, 1'b0, 1'b0);
      return;
    end
    idx  = int'(lg) - 1;
    live = sector_live[idx];
    old  = live ? sector_slot[idx] : '0;

    case (req)
      REQ_READ: expect_status(old, 1'b1, live, 1'b0);
      REQ_DELETE: begin
        if (!live) begin
          expect_status('0, 1'b1, 1'b0, 1'b0);
        end else begin
          sector_live[idx] = 1'b0;
          expect_cmd(CMD_MARK, old, HDR_USED);
          expect_status('0, mark, 1'b0, 1'b0);
        end
      end
      default: begin
        if (live && same) begin
          expect_status(old, 1'b1, 1'b1, 1'b0);
        end else if (store_is_full()) begin
          expect_status(old, 1'b0, live, 1'b0);
        end else begin
          // The new slot is consumed whatever happens after the program.
          fresh = SLOT_W'(next_slot);
          next_slot++;
          expect_cmd(CMD_PROGRAM, fresh, HDR_W'(lg));
          if (!prog) begin
            expect_status(old, 1'b0, live, 1'b0);
          end else if (live && !mark) begin
            sector_live[idx] = 1'b0;
            expect_cmd(CMD_MARK, old, HDR_USED);
            expect_status('0, 1'b0, 1'b0, 1'b0);
          end else begin
            if (live) expect_cmd(CMD_MARK, old, HDR_USED);
            sector_live[idx] = 1'b1;
            sector_slot[idx] = fresh;
            expect_status(fresh, 1'b1, 1'b1, 1'b0);
          end
        end
      end
    endcase
  endfunction

  task automatic report(string msg);
    $display("%0t  %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, cmd_t kind, logic [31:0] got,
                             logic [31:0] want);
    if (got !== want)
      report($sformatf("%s of %s result: got %0h, expected %0h",
                       name, kind.name(), got, want));
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LOGICAL; i++) sector_live[i] = 1'b0;
      next_slot   = 0;
      scan_halted = 1'b0;
      awaited_cmds.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_cmds.size() == 0) begin
          report($sformatf("result transfer with nothing awaited: kind %0d slot %0d",
                           out_tuser, out_tdata[7:0]));
        end else begin
          want = awaited_cmds.pop_front();
          check_field("cmd_kind", want.cmd_kind, 32'(out_tuser), 32'(want.cmd_kind));
          check_field("slot_index", want.cmd_kind, 32'(out_tdata[7:0]),
                      32'(want.slot_index));
          check_field("header_value", want.cmd_kind, 32'(out_tdata[23:8]),
                      32'(want.header_value));
          check_field("success", want.cmd_kind, 32'(out_tdata[24]), 32'(want.success));
          check_field("is_mapped", want.cmd_kind, 32'(out_tdata[25]),
                      32'(want.is_mapped));
          check_field("store_full", want.cmd_kind, 32'(out_tdata[26]),
                      32'(want.store_full));
          check_field("scan_finished", want.cmd_kind, 32'(out_tdata[27]),
                      32'(want.scan_finished));
          check_field("bad_header", want.cmd_kind, 32'(out_tdata[28]),
                      32'(want.bad_header));
          check_field("last_of_run", want.cmd_kind, 32'(out_tlast),
                      32'(want.last_of_run));
        end
      end
      if (in_tvalid && in_tready) predict_request(req_t'(in_tuser), in_tdata);
    end
    awaited_count = awaited_cmds.size();
  end

endmodule

### test/testbench.sv
module testbench;
  import fsrt_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_HOLD} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  int                     mismatch_count;
  int                     awaited_count;
  int                     burst_left;
  bit                     end_by_scan;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flash_sector_remap_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  remap_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  function automatic logic [IN_TDATA_W-1:0] req_word(logic [7:0] lg, logic [15:0] hdr,
                                                     logic erased, logic csum,
                                                     logic same, logic prog,
                                                     logic mark);
    return IN_TDATA_W'({mark, prog, same, csum, erased, hdr, lg});
  endfunction

  function automatic logic [7:0] random_sector();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'($urandom_range(NUM_LOGICAL_DEF + 1, 255));
    return 8'($urandom_range(1, NUM_LOGICAL_DEF));
  endfunction

  function automatic logic [15:0] random_header();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return HDR_USED;
    if (pick < 4) return HDR_FREE;
    if (pick < 8) return 16'($urandom_range(1, NUM_LOGICAL_DEF));
    if (pick == 8) return 16'($urandom_range(NUM_LOGICAL_DEF + 1, 16'hFFFE));
    return 16'($urandom);
  endfunction

  // Offers one request and returns at the edge where it transfers. The sender
  // works in bursts; valid only drops when a real gap follows.
  task automatic send(req_t req, logic [IN_TDATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(bit stop_allowed);
    req_t        req;
    logic [15:0] hdr;
    logic        erased;
    int          pick;
    pick   = $urandom_range(0, 99);
    req    = (pick < 25) ? REQ_SCAN : (pick < 60) ? REQ_WRITE :
             (pick < 75) ? REQ_DELETE : REQ_READ;
    hdr    = random_header();
    erased = 1'($urandom_range(0, 1));
    if (!stop_allowed && hdr == HDR_FREE) erased = 1'b0;
    send(req, req_word(random_sector(), hdr, erased, $urandom_range(0, 4) != 0,
                       $urandom_range(0, 2) == 0, $urandom_range(0, 4) != 0,
                       $urandom_range(0, 4) != 0));
  endtask

  task automatic drive_ready(rx_mode_t mode, int span);
    for (int k = 0; k < span; k++) begin
      case (mode)
        RX_OPEN:  out_tready <= 1'b1;
        RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
        RX_THIRD: out_tready <= (k % 3 == 0);
        default:  out_tready <= 1'b0;
      endcase
      @(posedge clk);
    end
  endtask

  // Result side: a mix of stall patterns, with one long hold-off early in the
  // random traffic so the block backs up into its input.
  initial begin
    rx_mode_t mode;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    repeat (4) drive_ready(rx_mode_t'($urandom_range(0, 2)), $urandom_range(20, 40));
    drive_ready(RX_HOLD, 100);
    forever begin
      mode = ($urandom_range(0, 7) == 0) ? RX_HOLD : rx_mode_t'($urandom_range(0, 2));
      drive_ready(mode, (mode == RX_HOLD) ? $urandom_range(20, 60)
                                          : $urandom_range(10, 80));
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    burst_left = 0;
    end_by_scan = 1'($urandom_range(0, 1));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out-of-range sector numbers on every request that takes one.
    send(REQ_READ,   req_word(8'd0,   HDR_USED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send(REQ_WRITE,  req_word(8'd17,  HDR_FREE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
    send(REQ_DELETE, req_word(8'd255, HDR_USED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    // Scan rebuild: good headers, checksum mismatch, used, free but written,
    // out-of-range headers and a rescan that moves sector 3.
    send(REQ_SCAN, req_word(8'd0, 16'd3, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send(REQ_SCAN, req_word(8'd0, 16'(NUM_LOGICAL_DEF), 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send(REQ_SCAN, req_word(8'd0, 16'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send(REQ_SCAN, req_word(8'd0, HDR_USED, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send(REQ_SCAN, req_word(8'd0, HDR_FREE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send(REQ_SCAN, req_word(8'd0, 16'(NUM_LOGICAL_DEF + 1), 1'b0, 1'b1, 1'b0, 1'b0,
                            1'b0));
    send(REQ_SCAN, req_word(8'd0, 16'hFFFE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send(REQ_SCAN, req_word(8'd0, 16'd3, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send(REQ_READ, req_word(8'd3, HDR_USED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Writes: unchanged data, same_data on an unmapped sector, program
    // failure, mark failure and a clean rewrite of a scanned sector.
    send(REQ_WRITE, req_word(8'd3, HDR_USED, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    send(REQ_WRITE, req_word(8'd5, HDR_USED, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    send(REQ_WRITE, req_word(8'd5, HDR_USED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send(REQ_WRITE, req_word(8'd5, HDR_USED, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send(REQ_WRITE, req_word(8'(NUM_LOGICAL_DEF), HDR_USED, 1'b0, 1'b0, 1'b0, 1'b1,
                             1'b1));
    // Deletes: normal, of an unmapped sector, and with a failed mark.
    send(REQ_DELETE, req_word(8'(NUM_LOGICAL_DEF), HDR_USED, 1'b0, 1'b0, 1'b0, 1'b0,
                              1'b1));
    send(REQ_DELETE, req_word(8'(NUM_LOGICAL_DEF), HDR_USED, 1'b0, 1'b0, 1'b0, 1'b0,
                              1'b1));
    send(REQ_DELETE, req_word(8'd3, HDR_USED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send(REQ_READ,   req_word(8'(NUM_LOGICAL_DEF), HDR_USED, 1'b0, 1'b0, 1'b0, 1'b0,
                              1'b0));
    send(REQ_READ,   req_word(8'hFF, HDR_FREE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send(REQ_WRITE,  req_word(8'd1, HDR_FREE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));

    repeat (100) send_random(1'b0);

    // The scan can end only once per run: either at an erased slot, after
    // which writes use up the store, or by scanning through the last slot.
    if (!end_by_scan) begin
      send(REQ_SCAN, req_word(8'd0, HDR_FREE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
      send(REQ_SCAN, req_word(8'd0, 16'd5, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    end
    repeat (NUM_SLOTS_DEF) begin
      if ($urandom_range(0, 7) == 0)
        send(REQ_READ, req_word(random_sector(), 16'($urandom), 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0));
      if (end_by_scan)
        send(REQ_SCAN, req_word(8'($urandom), random_header(), 1'b0,
                                $urandom_range(0, 4) != 0, 1'b0, 1'b0, 1'b0));
      else
        send(REQ_WRITE, req_word(8'($urandom_range(1, NUM_LOGICAL_DEF)), 16'($urandom),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'b0, $urandom_range(0, 6) != 0,
                                 $urandom_range(0, 6) != 0));
    end

    // Store is full now.
    send(REQ_WRITE, req_word(8'd4, HDR_USED, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send(REQ_SCAN,  req_word(8'd0, HDR_FREE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    repeat (10) send_random(1'b1);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
